[design/lpfc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpfc_pkg
// Shared types, codes and the CRC-16/CCITT-FALSE byte update for the
// length-prefixed frame checker.
// ----------------------------------------------------------------------------
package lpfc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [7:0]  MIN_LEN  = 8'd4;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_STATUS_CODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_CODE    = 2'd2;

    localparam logic [7:0] STATUS_CODE_RST  = 8'd1;
    localparam logic [7:0] COMMAND_CODE_RST = 8'd2;
    localparam logic [7:0] STOP_CODE_RST    = 8'd3;

    typedef enum logic [2:0] {
        VERDICT_STATUS  = 3'd0,
        VERDICT_CMD_OK  = 3'd1,
        VERDICT_BUSY    = 3'd2,
        VERDICT_STOP    = 3'd3,
        VERDICT_UNKNOWN = 3'd4,
        VERDICT_CRC_ERR = 3'd5,
        VERDICT_BAD_LEN = 3'd6
    } verdict_t;

    typedef struct packed {
        logic [7:0] status_type_code;
        logic [7:0] command_type_code;
        logic [7:0] stop_type_code;
    } type_codes_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  packet_type;
        logic [7:0]  frame_length;
        logic [15:0] crc_computed;
        logic [15:0] crc_received;
    } result_t;

    // MSB-first, unreflected, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[design/lpfc_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpfc_core
// Frame state (length, count, running CRC, type, tail bytes) and end-of-frame
// verdict. Updates once per enabled item except error items and zero lengths.
// ----------------------------------------------------------------------------
module lpfc_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_en,
    input  wire logic [7:0]            rx_byte,
    input  wire logic                  rx_error,
    input  wire logic                  controller_busy,
    input  wire lpfc_pkg::type_codes_t codes,
    output logic                       res_valid,
    output lpfc_pkg::result_t          res
);

    logic        in_frame_reg;
    logic [7:0]  len_reg;
    logic [7:0]  count_reg;
    logic [15:0] crc_reg;
    logic [7:0]  type_reg;
    logic [15:0] tail_reg;

    logic        take;
    logic        start;
    logic        done;
    logic [7:0]  len;
    logic [7:0]  idx;
    logic [8:0]  idx_plus2;
    logic [7:0]  count_next;
    logic [7:0]  type_next;
    logic [15:0] crc_next;
    logic [15:0] tail_next;
    logic        long_frame;

    always_comb
    begin
        start      = !in_frame_reg;
        take       = item_en && !rx_error && (in_frame_reg || (rx_byte != 8'd0));
        len        = start ? rx_byte : len_reg;
        idx        = start ? 8'd0 : count_reg;
        idx_plus2  = {1'b0, idx} + 9'd2;
        long_frame = (len >= lpfc_pkg::MIN_LEN);
        type_next  = start ? 8'd0 : type_reg;
        crc_next   = start ? lpfc_pkg::CRC_INIT : crc_reg;
        tail_next  = start ? 16'd0 : tail_reg;
        if (idx == 8'd1)
            type_next = rx_byte;
        if (long_frame)
        begin
            if (idx_plus2 < {1'b0, len})
                crc_next = lpfc_pkg::crc_byte(crc_next, rx_byte);
            else if (idx_plus2 == {1'b0, len})
                tail_next = {tail_next[15:8], rx_byte};
            else
                tail_next = {rx_byte, tail_next[7:0]};
        end
        count_next = idx + 8'd1;
        done       = (count_next == len);
    end

    always_comb
    begin
        res.packet_type  = type_next;
        res.frame_length = len;
        res.crc_computed = long_frame ? crc_next : 16'd0;
        res.crc_received = long_frame ? tail_next : 16'd0;
        if (!long_frame)
            res.verdict = lpfc_pkg::VERDICT_BAD_LEN;
        else if (crc_next != tail_next)
            res.verdict = lpfc_pkg::VERDICT_CRC_ERR;
        else if (type_next == codes.status_type_code)
            res.verdict = lpfc_pkg::VERDICT_STATUS;
        else if (type_next == codes.command_type_code)
            res.verdict = controller_busy ? lpfc_pkg::VERDICT_BUSY
                                          : lpfc_pkg::VERDICT_CMD_OK;
        else if (type_next == codes.stop_type_code)
            res.verdict = lpfc_pkg::VERDICT_STOP;
        else
            res.verdict = lpfc_pkg::VERDICT_UNKNOWN;
        res_valid = take && done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            len_reg      <= 8'd0;
            count_reg    <= 8'd0;
            crc_reg      <= lpfc_pkg::CRC_INIT;
            type_reg     <= 8'd0;
            tail_reg     <= 16'd0;
        end
        else if (take)
        begin
            if (done)
            begin
                in_frame_reg <= 1'b0;
                len_reg      <= 8'd0;
                count_reg    <= 8'd0;
                crc_reg      <= lpfc_pkg::CRC_INIT;
                type_reg     <= 8'd0;
                tail_reg     <= 16'd0;
            end
            else
            begin
                in_frame_reg <= 1'b1;
                len_reg      <= len;
                count_reg    <= count_next;
                crc_reg      <= crc_next;
                type_reg     <= type_next;
                tail_reg     <= tail_next;
            end
        end
    end

endmodule

`default_nettype wire

[design/length_prefixed_frame_checker_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker_top
// Length-prefixed frame receiver with CRC-16/CCITT-FALSE check and verdict.
// ----------------------------------------------------------------------------
// Accepts one received byte item per cycle, sustained, for as long as the
// result side is not stalled. An item passes an input register, then the
// frame state update (one unrolled CRC byte step) writes the result register,
// so a verdict is presented from the result register after the last byte of
// a frame has passed the input register and the state update. Only the last
// byte of a frame yields a result item; error-flagged bytes and zero length
// bytes are dropped. Type codes are written over the cfg port, which is always
// ready and should be used only while no frame is in flight.
// ----------------------------------------------------------------------------
module length_prefixed_frame_checker_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [7:0]                     rx_byte,
    input  wire logic                           rx_error,
    input  wire logic                           controller_busy,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [2:0]                          verdict,
    output logic [7:0]                          packet_type,
    output logic [7:0]                          frame_length,
    output logic [15:0]                         crc_computed,
    output logic [15:0]                         crc_received,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [lpfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data
);

    lpfc_pkg::type_codes_t codes_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_error_reg;
    logic       s1_busy_reg;

    logic              out_valid_reg;
    lpfc_pkg::result_t out_reg;

    logic              go;
    logic              in_accept;
    logic              res_valid;
    lpfc_pkg::result_t res;

    assign cfg_ready = 1'b1;
    assign go        = !(out_valid_reg && out_stall);
    assign in_stall  = s1_valid_reg && !go;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg.status_type_code  <= lpfc_pkg::STATUS_CODE_RST;
            codes_reg.command_type_code <= lpfc_pkg::COMMAND_CODE_RST;
            codes_reg.stop_type_code    <= lpfc_pkg::STOP_CODE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lpfc_pkg::CFG_STATUS_CODE:  codes_reg.status_type_code  <= cfg_data;
                lpfc_pkg::CFG_COMMAND_CODE: codes_reg.command_type_code <= cfg_data;
                lpfc_pkg::CFG_STOP_CODE:    codes_reg.stop_type_code    <= cfg_data;
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_accept)
            s1_valid_reg <= 1'b1;
        else if (go)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg  <= rx_byte;
            s1_error_reg <= rx_error;
            s1_busy_reg  <= controller_busy;
        end
    end

    lpfc_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_en         (s1_valid_reg && go),
        .rx_byte         (s1_byte_reg),
        .rx_error        (s1_error_reg),
        .controller_busy (s1_busy_reg),
        .codes           (codes_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            out_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign verdict      = out_reg.verdict;
    assign packet_type  = out_reg.packet_type;
    assign frame_length = out_reg.frame_length;
    assign crc_computed = out_reg.crc_computed;
    assign crc_received = out_reg.crc_received;

endmodule

`default_nettype wire

[design/lpfc_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpfc_checker
// Port-level checks on the frame checker's result items.
// ----------------------------------------------------------------------------
module lpfc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [2:0]  verdict,
    input wire logic [7:0]  packet_type,
    input wire logic [7:0]  frame_length,
    input wire logic [15:0] crc_computed,
    input wire logic [15:0] crc_received
);

    logic bad_len;
    logic crc_err;

    assign bad_len = (verdict == lpfc_pkg::VERDICT_BAD_LEN);
    assign crc_err = (verdict == lpfc_pkg::VERDICT_CRC_ERR);

    a_len_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((frame_length < lpfc_pkg::MIN_LEN) == bad_len))
        else $error("bad length verdict does not match frame length");

    a_short_crc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_len) |-> (crc_computed == 16'd0 && crc_received == 16'd0))
        else $error("short frame reports nonzero CRC");

    a_crc_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !bad_len) |-> ((crc_computed != crc_received) == crc_err))
        else $error("CRC verdict does not match CRC fields");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(verdict)
            && $stable(packet_type) && $stable(frame_length)
            && $stable(crc_computed) && $stable(crc_received)))
        else $error("stalled result item changed");

endmodule

bind length_prefixed_frame_checker_top lpfc_checker u_lpfc_checker (.*);

`default_nettype wire

[dv/frame_verdict_checker.sv]
// ----------------------------------------------------------------------------
// frame_verdict_checker
// Watches the byte, verdict and type-code channels of the frame checker. It
// tracks frame state and CRC for each accepted byte not flagged as an error,
// queues each frame-end verdict, then compares them field by field in order.
// ----------------------------------------------------------------------------
module frame_verdict_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    input  wire logic                           in_stall,
    input  wire logic [7:0]                     rx_byte,
    input  wire logic                           rx_error,
    input  wire logic                           controller_busy,
    input  wire logic                           out_valid,
    input  wire logic                           out_stall,
    input  wire logic [2:0]                     verdict,
    input  wire logic [7:0]                     packet_type,
    input  wire logic [7:0]                     frame_length,
    input  wire logic [15:0]                    crc_computed,
    input  wire logic [15:0]                    crc_received,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [lpfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,
    output int                                  failures,
    output int                                  pending,
    output int                                  results_checked,
    output logic [6:0]                          verdicts_seen
);

    lpfc_pkg::type_codes_t codes;
    logic                  framing;
    logic [7:0]            frame_len;
    logic [7:0]            bytes_in;
    logic [15:0]           crc_acc;
    logic [7:0]            type_seen;
    logic [15:0]           crc_tail;
    lpfc_pkg::result_t     verdict_q[$];

    // bit-serial CCITT update, message bit MSB first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          k;
        c = crc;
        for (k = 7; k >= 0; k--)
        begin
            if (c[15] ^ b[k])
                c = {c[14:0], 1'b0} ^ lpfc_pkg::CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic int field_miss(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got === want)
            return 0;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        return 1;
    endfunction

    task automatic predict_byte(input logic [7:0] b, input logic busy);
        logic [7:0]        idx;
        lpfc_pkg::result_t r;
        if (!framing)
        begin
            // zero while waiting for a length is not a frame
            if (b == 8'd0)
                return;
            framing   = 1'b1;
            frame_len = b;
            bytes_in  = 8'd0;
            crc_acc   = lpfc_pkg::CRC_INIT;
            type_seen = 8'd0;
            crc_tail  = 16'd0;
        end
        idx = bytes_in;
        if (idx == 8'd1)
            type_seen = b;
        if (frame_len >= lpfc_pkg::MIN_LEN)
        begin
            if (int'(idx) + 2 < int'(frame_len))
                crc_acc = crc_update(crc_acc, b);
            else if (int'(idx) + 2 == int'(frame_len))
                crc_tail[7:0] = b;
            else
                crc_tail[15:8] = b;
        end
        bytes_in = bytes_in + 8'd1;
        if (bytes_in != frame_len)
            return;
        r.packet_type  = type_seen;
        r.frame_length = frame_len;
        r.crc_computed = 16'd0;
        r.crc_received = 16'd0;
        if (frame_len < lpfc_pkg::MIN_LEN)
            r.verdict = lpfc_pkg::VERDICT_BAD_LEN;
        else
        begin
            r.crc_computed = crc_acc;
            r.crc_received = crc_tail;
            // equal codes: status beats command beats stop
            if (crc_acc != crc_tail)
                r.verdict = lpfc_pkg::VERDICT_CRC_ERR;
            else if (type_seen == codes.status_type_code)
                r.verdict = lpfc_pkg::VERDICT_STATUS;
            else if (type_seen == codes.command_type_code)
                r.verdict = busy ? lpfc_pkg::VERDICT_BUSY : lpfc_pkg::VERDICT_CMD_OK;
            else if (type_seen == codes.stop_type_code)
                r.verdict = lpfc_pkg::VERDICT_STOP;
            else
                r.verdict = lpfc_pkg::VERDICT_UNKNOWN;
        end
        verdict_q.push_back(r);
        framing = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lpfc_pkg::result_t want;
        if (!rst_n)
        begin
            codes           = '{lpfc_pkg::STATUS_CODE_RST, lpfc_pkg::COMMAND_CODE_RST,
                                lpfc_pkg::STOP_CODE_RST};
            framing         = 1'b0;
            frame_len       = 8'd0;
            bytes_in        = 8'd0;
            crc_acc         = lpfc_pkg::CRC_INIT;
            type_seen       = 8'd0;
            crc_tail        = 16'd0;
            verdict_q.delete();
            failures        = 0;
            pending         = 0;
            results_checked = 0;
            verdicts_seen   = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("verdict item with none expected: verdict %0d, length %0d",
                           verdict, frame_length);
                    failures++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    results_checked++;
                    verdicts_seen[int'(want.verdict)] = 1'b1;
                    failures += field_miss("verdict", 16'(want.verdict), 16'(verdict));
                    failures += field_miss("packet_type", 16'(want.packet_type),
                                           16'(packet_type));
                    failures += field_miss("frame_length", 16'(want.frame_length),
                                           16'(frame_length));
                    failures += field_miss("crc_computed", want.crc_computed, crc_computed);
                    failures += field_miss("crc_received", want.crc_received, crc_received);
                end
            end
            if (in_valid && !in_stall && !rx_error)
                predict_byte(rx_byte, controller_busy);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    lpfc_pkg::CFG_STATUS_CODE:  codes.status_type_code  = cfg_data;
                    lpfc_pkg::CFG_COMMAND_CODE: codes.command_type_code = cfg_data;
                    lpfc_pkg::CFG_STOP_CODE:    codes.stop_type_code    = cfg_data;
                    default: ;
                endcase
            end
            pending = verdict_q.size();
        end
    end

endmodule

[dv/length_prefixed_frame_checker_top_tb.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_checker_top_tb
// Drives byte items into the frame checker: a directed set of short, valid,
// corrupt and busy frames, then random frames under several type-code
// settings with dropped bytes, zero bytes, bad CRCs, short lengths, a
// maximum-length frame, random stalls and a long receiver hold-off.
// ----------------------------------------------------------------------------
module length_prefixed_frame_checker_top_tb;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 112;
    localparam int NUM_PHASES  = 6;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic [7:0]                     rx_byte;
    logic                           rx_error;
    logic                           controller_busy;
    logic                           out_valid;
    logic                           out_stall;
    logic [2:0]                     verdict;
    logic [7:0]                     packet_type;
    logic [7:0]                     frame_length;
    logic [15:0]                    crc_computed;
    logic [15:0]                    crc_received;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [lpfc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [7:0]                     cfg_data;

    int          failures;
    int          pending;
    int          results_checked;
    logic [6:0]  verdicts_seen;

    lpfc_pkg::type_codes_t codes_now;
    int          idle_pct;
    int          busy_pct;
    int          noise_pct;
    bit          calm;
    bit          hold_req;
    int          frames_sent;
    int          frame_bytes_sent;
    int          noise_sent;
    int          idle_cycles;

    length_prefixed_frame_checker_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .rx_error        (rx_error),
        .controller_busy (controller_busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .verdict         (verdict),
        .packet_type     (packet_type),
        .frame_length    (frame_length),
        .crc_computed    (crc_computed),
        .crc_received    (crc_received),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    frame_verdict_checker u_verdict_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_byte         (rx_byte),
        .rx_error        (rx_error),
        .controller_busy (controller_busy),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .verdict         (verdict),
        .packet_type     (packet_type),
        .frame_length    (frame_length),
        .crc_computed    (crc_computed),
        .crc_received    (crc_received),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .pending         (pending),
        .results_checked (results_checked),
        .verdicts_seen   (verdicts_seen)
    );

    initial
        clk = 1'b0;

    always #5 clk = ~clk;

    // verdict receiver: random stalls, one long hold-off when requested
    initial
    begin : receiver
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !calm && ($urandom_range(0, 99) < 18);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ends just after the accepting edge; the next call or a pause owns in_valid
    task automatic push_byte(input logic [7:0] b, input logic err, input logic busy);
        @(negedge clk);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid        <= 1'b1;
        rx_byte         <= b;
        rx_error        <= err;
        controller_busy <= busy;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic sender_quiet();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic send_frame(input int len, input logic [7:0] ptype, input bit bad_crc);
        logic [7:0]  fb [255];
        logic [15:0] crc;
        int          i;
        int          k;
        fb[0] = 8'(len);
        for (i = 1; i < len; i++)
            fb[i] = 8'($urandom);
        if (len > 1)
            fb[1] = ptype;
        if (len >= 4)
        begin
            crc = lpfc_pkg::CRC_INIT;
            for (i = 0; i < len - 2; i++)
            begin
                crc = crc ^ {fb[i], 8'h00};
                for (k = 0; k < 8; k++)
                    crc = crc[15] ? ((crc << 1) ^ lpfc_pkg::CRC_POLY) : (crc << 1);
            end
            if (bad_crc)
                crc = crc ^ (16'd1 << $urandom_range(0, 15));
            fb[len-2] = crc[7:0];
            fb[len-1] = crc[15:8];
        end
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct)
            begin
                push_byte(8'($urandom), 1'b1, 1'($urandom));
                noise_sent++;
            end
            push_byte(fb[i], 1'b0, $urandom_range(0, 99) < busy_pct);
        end
        frames_sent++;
        frame_bytes_sent += len;
    endtask

    initial
    begin : stimulus
        lpfc_pkg::type_codes_t          plan [NUM_PHASES];
        logic [lpfc_pkg::CFG_IDX_W-1:0] reg_idx [3];
        logic [7:0]                     reg_val [3];
        int                             p;
        int                             j;
        int                             r;
        int                             len;
        int                             target;
        logic [7:0]                     t;

        rst_n            = 1'b0;
        in_valid         = 1'b0;
        rx_byte          = 8'd0;
        rx_error         = 1'b0;
        controller_busy  = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = lpfc_pkg::CFG_STATUS_CODE;
        cfg_data         = 8'd0;
        hold_req         = 1'b0;
        calm             = 1'b0;
        idle_pct         = 0;
        busy_pct         = 0;
        noise_pct        = 0;
        frames_sent      = 0;
        frame_bytes_sent = 0;
        noise_sent       = 0;
        idle_cycles      = 0;
        codes_now        = '{lpfc_pkg::STATUS_CODE_RST, lpfc_pkg::COMMAND_CODE_RST,
                             lpfc_pkg::STOP_CODE_RST};

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b1);
        noise_sent += 2;
        send_frame(1, 8'h00, 1'b0);
        busy_pct = 100;
        send_frame(3, 8'hFF, 1'b0);
        send_frame(4, lpfc_pkg::STATUS_CODE_RST, 1'b0);
        send_frame(4, lpfc_pkg::COMMAND_CODE_RST, 1'b0);
        busy_pct = 0;
        send_frame(4, lpfc_pkg::STOP_CODE_RST, 1'b0);
        noise_pct = 100;
        send_frame(4, 8'h7E, 1'b0);
        noise_pct = 0;
        send_frame(4, lpfc_pkg::STATUS_CODE_RST, 1'b1);

        plan[0] = '{lpfc_pkg::STATUS_CODE_RST, lpfc_pkg::COMMAND_CODE_RST,
                    lpfc_pkg::STOP_CODE_RST};
        plan[1] = '{8'h00, 8'hFF, 8'h80};
        plan[2] = '{8'hFF, 8'h00, 8'hFF};
        plan[3] = '{8'h5A, 8'h5A, 8'h5A};
        plan[4] = '{8'($urandom), 8'($urandom), 8'($urandom)};
        plan[5] = '{8'h02, 8'h02, 8'h01};
        reg_idx = '{lpfc_pkg::CFG_STATUS_CODE, lpfc_pkg::CFG_COMMAND_CODE,
                    lpfc_pkg::CFG_STOP_CODE};

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // type codes change only with nothing in flight
            sender_quiet();
            while (pending != 0)
                @(negedge clk);
            repeat (4) @(negedge clk);
            reg_val = '{plan[p].status_type_code, plan[p].command_type_code,
                        plan[p].stop_type_code};
            for (j = 0; j < 3; j++)
            begin
                cfg_valid <= 1'b1;
                cfg_index <= reg_idx[j];
                cfg_data  <= reg_val[j];
                do
                    @(posedge clk);
                while (!cfg_ready);
                @(negedge clk);
            end
            cfg_valid <= 1'b0;
            codes_now = plan[p];

            calm      = (p == 3);
            idle_pct  = calm ? 0 : 18;
            busy_pct  = 50;
            noise_pct = 4;
            if (p == 1)
                hold_req = 1'b1;

            target = frame_bytes_sent + PHASE_BYTES;
            if (p == 4)
                send_frame(255, codes_now.command_type_code, 1'b0);
            while (frame_bytes_sent < target)
            begin
                if ($urandom_range(0, 99) < noise_pct)
                begin
                    push_byte(8'h00, 1'b0, 1'($urandom));
                    noise_sent++;
                end
                r = $urandom_range(0, 99);
                if (r < 6)
                    len = $urandom_range(1, 3);
                else if (r < 14)
                    len = $urandom_range(13, 48);
                else
                    len = $urandom_range(4, 12);
                r = $urandom_range(0, 9);
                if (r < 3)
                    t = codes_now.status_type_code;
                else if (r < 6)
                    t = codes_now.command_type_code;
                else if (r < 8)
                    t = codes_now.stop_type_code;
                else
                    t = 8'($urandom);
                send_frame(len, t, $urandom_range(0, 99) < 12);
            end
        end

        sender_quiet();
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        $display("Sent %0d frames, %0d frame bytes and %0d dropped or zero bytes",
                 frames_sent, frame_bytes_sent, noise_sent);
        $display("Checked %0d verdicts over %0d code sets; kinds seen (bad length to status): %b",
                 results_checked, NUM_PHASES, verdicts_seen);
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[length_prefixed_frame_checker_top.f]
design/lpfc_pkg.sv
design/lpfc_core.sv
design/length_prefixed_frame_checker_top.sv
design/lpfc_checker.sv
dv/frame_verdict_checker.sv
dv/length_prefixed_frame_checker_top_tb.sv
